>>> design/ipv6f_pkg.sv
// Shared types, microprogram and character helpers for the IPv6 address text formatter.
package ipv6f_pkg;

    // Program counter and the step addresses of the microprogram.
    typedef logic [3:0] t_pc;

    localparam t_pc P_SCAN    = 4'd0;
    localparam t_pc P_LOOP    = 4'd1;
    localparam t_pc P_SEP     = 4'd2;
    localparam t_pc P_RUNCHK  = 4'd3;
    localparam t_pc P_NIBINIT = 4'd4;
    localparam t_pc P_NIB     = 4'd5;
    localparam t_pc P_NEXTGRP = 4'd6;
    localparam t_pc P_Z0      = 4'd7;
    localparam t_pc P_Z1      = 4'd8;
    localparam t_pc P_D0      = 4'd9;
    localparam t_pc P_D1      = 4'd10;
    localparam t_pc P_DH      = 4'd11;
    localparam t_pc P_DT      = 4'd12;
    localparam t_pc P_DO      = 4'd13;
    localparam t_pc P_DDOT    = 4'd14;
    localparam t_pc P_END     = 4'd15;

    // Character source of a step.
    typedef logic [2:0] t_emit;
    localparam t_emit EM_NONE  = 3'd0;
    localparam t_emit EM_COLON = 3'd1;
    localparam t_emit EM_DOT   = 3'd2;
    localparam t_emit EM_HEX   = 3'd3;
    localparam t_emit EM_DEC_H = 3'd4;
    localparam t_emit EM_DEC_T = 3'd5;
    localparam t_emit EM_DEC_O = 3'd6;

    // Condition under which the character is actually sent.
    typedef logic [2:0] t_econd;
    localparam t_econd EC_ALWAYS  = 3'd0;
    localparam t_econd EC_K_NZ    = 3'd1;
    localparam t_econd EC_K_ZERO  = 3'd2;
    localparam t_econd EC_K_END   = 3'd3;
    localparam t_econd EC_HEX_SIG = 3'd4;
    localparam t_econd EC_B100    = 3'd5;
    localparam t_econd EC_B10     = 3'd6;

    // Condition that marks the character as the final one of the text.
    typedef logic [1:0] t_lcond;
    localparam t_lcond LC_NONE   = 2'd0;
    localparam t_lcond LC_ALWAYS = 2'd1;
    localparam t_lcond LC_HEXEND = 2'd2;
    localparam t_lcond LC_BYTE3  = 2'd3;

    // Jump condition; a taken jump loads the target, otherwise the step counter advances.
    typedef logic [2:0] t_jcond;
    localparam t_jcond JC_NEXT    = 3'd0;
    localparam t_jcond JC_ALWAYS  = 3'd1;
    localparam t_jcond JC_DOTTED  = 3'd2;
    localparam t_jcond JC_KEND    = 3'd3;
    localparam t_jcond JC_RUNHIT  = 3'd4;
    localparam t_jcond JC_NIBMORE = 3'd5;
    localparam t_jcond JC_BYTE3   = 3'd6;

    // Counter actions of a step.
    typedef logic [2:0] t_act;
    localparam t_act AC_NONE    = 3'd0;
    localparam t_act AC_SCAN    = 3'd1;
    localparam t_act AC_KADDRUN = 3'd2;
    localparam t_act AC_NIBINIT = 3'd3;
    localparam t_act AC_NIBSTEP = 3'd4;
    localparam t_act AC_BINIT   = 3'd5;
    localparam t_act AC_BINC    = 3'd6;
    localparam t_act AC_END     = 3'd7;

    // One control word of the microprogram.
    typedef struct packed {
        t_emit  emit;
        t_econd econd;
        t_lcond lcond;
        t_jcond jcond;
        t_pc    target;
        t_act   act;
    } t_uword;

    // Longest zero-group run: first group and number of groups.
    typedef struct packed {
        logic [2:0] start;
        logic [3:0] len;
    } t_run;

    // Decimal digits of one byte.
    typedef struct packed {
        logic [1:0] h;
        logic [3:0] t;
        logic [3:0] o;
    } t_dec;

    localparam logic [6:0] CH_ZERO  = 7'h30;
    localparam logic [6:0] CH_A     = 7'h61;
    localparam logic [6:0] CH_COLON = 7'h3a;
    localparam logic [6:0] CH_DOT   = 7'h2e;

    // The microprogram: hex groups with one compressed run, or the dotted-quad tail form.
    function automatic t_uword f_ucode(input t_pc pc);
        t_uword w;
        w = '{EM_NONE, EC_ALWAYS, LC_NONE, JC_NEXT, P_SCAN, AC_NONE};
        case (pc)
            P_SCAN:    w = '{EM_NONE,  EC_ALWAYS,  LC_NONE,   JC_DOTTED,  P_D0,   AC_SCAN};
            P_LOOP:    w = '{EM_NONE,  EC_ALWAYS,  LC_NONE,   JC_KEND,    P_END,  AC_NONE};
            P_SEP:     w = '{EM_COLON, EC_K_NZ,    LC_NONE,   JC_NEXT,    P_SCAN, AC_NONE};
            P_RUNCHK:  w = '{EM_NONE,  EC_ALWAYS,  LC_NONE,   JC_RUNHIT,  P_Z0,   AC_NONE};
            P_NIBINIT: w = '{EM_NONE,  EC_ALWAYS,  LC_NONE,   JC_NEXT,    P_SCAN, AC_NIBINIT};
            P_NIB:     w = '{EM_HEX,   EC_HEX_SIG, LC_HEXEND, JC_NIBMORE, P_NIB,  AC_NIBSTEP};
            P_NEXTGRP: w = '{EM_NONE,  EC_ALWAYS,  LC_NONE,   JC_ALWAYS,  P_LOOP, AC_NONE};
            P_Z0:      w = '{EM_COLON, EC_K_ZERO,  LC_NONE,   JC_NEXT,    P_SCAN, AC_KADDRUN};
            P_Z1:      w = '{EM_COLON, EC_K_END,   LC_ALWAYS, JC_ALWAYS,  P_LOOP, AC_NONE};
            P_D0:      w = '{EM_COLON, EC_ALWAYS,  LC_NONE,   JC_NEXT,    P_SCAN, AC_BINIT};
            P_D1:      w = '{EM_COLON, EC_ALWAYS,  LC_NONE,   JC_NEXT,    P_SCAN, AC_NONE};
            P_DH:      w = '{EM_DEC_H, EC_B100,    LC_NONE,   JC_NEXT,    P_SCAN, AC_NONE};
            P_DT:      w = '{EM_DEC_T, EC_B10,     LC_NONE,   JC_NEXT,    P_SCAN, AC_NONE};
            P_DO:      w = '{EM_DEC_O, EC_ALWAYS,  LC_BYTE3,  JC_BYTE3,   P_END,  AC_BINC};
            P_DDOT:    w = '{EM_DOT,   EC_ALWAYS,  LC_NONE,   JC_ALWAYS,  P_DH,   AC_NONE};
            P_END:     w = '{EM_NONE,  EC_ALWAYS,  LC_NONE,   JC_NEXT,    P_SCAN, AC_END};
            default:   w = '{EM_NONE,  EC_ALWAYS,  LC_NONE,   JC_NEXT,    P_SCAN, AC_END};
        endcase
        return w;
    endfunction

    // Lower-case hex digit character.
    function automatic logic [6:0] f_hex_char(input logic [3:0] d);
        logic [6:0] c;
        if (d < 4'd10) begin
            c = CH_ZERO + {3'b000, d};
        end else begin
            c = CH_A + {3'b000, d} - 7'd10;
        end
        return c;
    endfunction

    // Splits a byte into hundreds, tens and ones; tens by reciprocal multiply (205 / 2048).
    function automatic t_dec f_dec_digits(input logic [7:0] b);
        t_dec        r;
        logic [7:0]  rem8;
        logic [6:0]  rem;
        logic [14:0] prod;
        if (b >= 8'd200) begin
            r.h  = 2'd2;
            rem8 = b - 8'd200;
        end else if (b >= 8'd100) begin
            r.h  = 2'd1;
            rem8 = b - 8'd100;
        end else begin
            r.h  = 2'd0;
            rem8 = b;
        end
        rem  = rem8[6:0];
        prod = {8'd0, rem} * 15'd205;
        r.t  = prod[14:11];
        r.o  = 4'(rem - 7'({3'b000, r.t} * 7'd10));
        return r;
    endfunction

endpackage

>>> design/ipv6f_intf.sv
// Valid/ready channel interfaces for addresses in and characters out.
interface ipv6f_addr_if;
    logic        valid;
    logic        ready;
    logic [63:0] addr_high;
    logic [63:0] addr_low;

    modport source (output valid, output addr_high, output addr_low, input ready);
    modport sink   (input valid, input addr_high, input addr_low, output ready);
endinterface

interface ipv6f_char_if;
    logic       valid;
    logic       ready;
    logic [6:0] out_char;
    logic       last_char;

    modport source (output valid, output out_char, output last_char, input ready);
    modport sink   (input valid, input out_char, input last_char, output ready);
endinterface

>>> design/ipv6f_zero_run.sv
// Finder of the longest run of zero groups, earliest run winning a tie.
module ipv6f_zero_run import ipv6f_pkg::*; (
    input  logic [7:0] i_zero_mask,
    output t_run       o_run
);

    logic [2:0] run_start;
    logic [3:0] run_len;

    // Walk the eight groups once, keeping the best run seen so far.
    always_comb begin
        o_run     = '0;
        run_start = '0;
        run_len   = '0;
        for (int g = 0; g < 8; g++) begin
            if (i_zero_mask[g]) begin
                if (run_len == 4'd0) begin
                    run_start = 3'(g);
                end
                run_len = run_len + 4'd1;
                if (run_len > o_run.len) begin
                    o_run.len   = run_len;
                    o_run.start = run_start;
                end
            end else begin
                run_len = '0;
            end
        end
    end

endmodule

>>> design/ipv6_address_text_formatter.sv
// IPv6 address text formatter: takes one 128-bit address and sends its text form one ASCII
// character per item, the final character flagged by last_char. The block handles one address
// at a time; a small microprogram in a constant table steps through the text, one step per
// cycle, and a step that sends a character waits while the output register is still full.
// An address in hex form takes up to 75 steps (one scan step, nine steps per printed group,
// five steps for the compressed run, one closing loop step and the end step), the longest
// case being an address with no zero group; the dotted-quad form takes 19 steps. Cycles the
// character consumer stalls add to these; the next address is taken the cycle after the
// last step.
module ipv6_address_text_formatter import ipv6f_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ipv6f_addr_if.sink    i_addr,
    ipv6f_char_if.source  o_char
);

    logic             r_busy, n_busy;
    t_pc              r_pc, n_pc;
    logic [7:0][15:0] r_grp;
    t_run             r_run, n_run;
    logic [3:0]       r_k, n_k;
    logic [1:0]       r_nib, n_nib;
    logic             r_started, n_started;
    logic [1:0]       r_byte, n_byte;
    logic             r_out_valid, n_out_valid;
    logic [6:0]       r_out_char, n_out_char;
    logic             r_out_last, n_out_last;

    t_uword     w;
    t_run       scan_run;
    logic [7:0] zero_mask;
    logic       dotted;
    logic       accept;
    logic       out_free;
    logic       econd_ok;
    logic       emit_req;
    logic       step_go;
    logic       jump;
    logic       is_last;
    logic [6:0] ch;
    logic [15:0] cur_grp;
    logic [3:0] nib;
    logic [7:0] cur_byte;
    t_dec       dec;

    assign accept       = i_addr.valid && i_addr.ready;
    assign i_addr.ready = !r_busy;

    // Zero-group mask and longest-run search over the held address.
    always_comb begin
        for (int g = 0; g < 8; g++) begin
            zero_mask[g] = (r_grp[g] == 16'd0);
        end
    end

    ipv6f_zero_run u_zero_run (
        .i_zero_mask (zero_mask),
        .o_run       (scan_run)
    );

    assign dotted = (scan_run.start == 3'd0) && (scan_run.len == 4'd6);

    // Datapath operands: current hex digit and decimal digits of the current byte.
    assign cur_grp = r_grp[r_k[2:0]];
    assign nib     = cur_grp[{r_nib, 2'b00} +: 4];

    always_comb begin
        case (r_byte)
            2'd0:    cur_byte = r_grp[6][15:8];
            2'd1:    cur_byte = r_grp[6][7:0];
            2'd2:    cur_byte = r_grp[7][15:8];
            default: cur_byte = r_grp[7][7:0];
        endcase
    end

    assign dec = f_dec_digits(cur_byte);

    // Decode of the current control word.
    assign w = f_ucode(r_pc);

    always_comb begin
        case (w.econd)
            EC_ALWAYS:  econd_ok = 1'b1;
            EC_K_NZ:    econd_ok = (r_k != 4'd0);
            EC_K_ZERO:  econd_ok = (r_k == 4'd0);
            EC_K_END:   econd_ok = r_k[3];
            EC_HEX_SIG: econd_ok = (nib != 4'd0) || r_started || (r_nib == 2'd0);
            EC_B100:    econd_ok = (cur_byte >= 8'd100);
            EC_B10:     econd_ok = (cur_byte >= 8'd10);
            default:    econd_ok = 1'b0;
        endcase
    end

    always_comb begin
        case (w.emit)
            EM_COLON: ch = CH_COLON;
            EM_DOT:   ch = CH_DOT;
            EM_HEX:   ch = f_hex_char(nib);
            EM_DEC_H: ch = CH_ZERO + {5'd0, dec.h};
            EM_DEC_T: ch = CH_ZERO + {3'd0, dec.t};
            EM_DEC_O: ch = CH_ZERO + {3'd0, dec.o};
            default:  ch = CH_ZERO;
        endcase
    end

    always_comb begin
        case (w.lcond)
            LC_ALWAYS: is_last = 1'b1;
            LC_HEXEND: is_last = (r_k == 4'd7) && (r_nib == 2'd0);
            LC_BYTE3:  is_last = (r_byte == 2'd3);
            default:   is_last = 1'b0;
        endcase
    end

    always_comb begin
        case (w.jcond)
            JC_ALWAYS:  jump = 1'b1;
            JC_DOTTED:  jump = dotted;
            JC_KEND:    jump = r_k[3];
            JC_RUNHIT:  jump = (r_k == {1'b0, r_run.start}) && (r_run.len != 4'd0);
            JC_NIBMORE: jump = (r_nib != 2'd0);
            JC_BYTE3:   jump = (r_byte == 2'd3);
            default:    jump = 1'b0;
        endcase
    end

    assign out_free = !r_out_valid || o_char.ready;
    assign emit_req = (w.emit != EM_NONE) && econd_ok;
    assign step_go  = r_busy && !(emit_req && !out_free);

    // Next state of the sequencer and its counters.
    always_comb begin
        n_busy    = r_busy;
        n_pc      = r_pc;
        n_run     = r_run;
        n_k       = r_k;
        n_nib     = r_nib;
        n_started = r_started;
        n_byte    = r_byte;
        if (accept) begin
            n_busy = 1'b1;
            n_pc   = P_SCAN;
        end else if (step_go) begin
            n_pc = jump ? w.target : r_pc + 4'd1;
            case (w.act)
                AC_SCAN: begin
                    n_run = scan_run;
                    n_k   = 4'd0;
                end
                AC_KADDRUN: n_k = r_k + r_run.len;
                AC_NIBINIT: begin
                    n_nib     = 2'd3;
                    n_started = 1'b0;
                end
                AC_NIBSTEP: begin
                    if (emit_req) begin
                        n_started = 1'b1;
                    end
                    if (r_nib != 2'd0) begin
                        n_nib = r_nib - 2'd1;
                    end else begin
                        n_k = r_k + 4'd1;
                    end
                end
                AC_BINIT: n_byte = 2'd0;
                AC_BINC:  n_byte = r_byte + 2'd1;
                AC_END:   n_busy = 1'b0;
                default:  n_busy = r_busy;
            endcase
        end
    end

    // Output register: loaded by a sending step, freed when the consumer takes the item.
    always_comb begin
        n_out_valid = r_out_valid;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;
        if (step_go && emit_req) begin
            n_out_valid = 1'b1;
            n_out_char  = ch;
            n_out_last  = is_last;
        end else if (o_char.ready) begin
            n_out_valid = 1'b0;
        end
    end

    assign o_char.valid     = r_out_valid;
    assign o_char.out_char  = r_out_char;
    assign o_char.last_char = r_out_last;

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_pc        <= P_SCAN;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_pc        <= n_pc;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload and counter registers.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            for (int g = 0; g < 4; g++) begin
                r_grp[g]     <= i_addr.addr_high[63 - 16 * g -: 16];
                r_grp[g + 4] <= i_addr.addr_low[63 - 16 * g -: 16];
            end
        end
        r_run      <= n_run;
        r_k        <= n_k;
        r_nib      <= n_nib;
        r_started  <= n_started;
        r_byte     <= n_byte;
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
    end

    // An accepted address always starts the program at the scan step.
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_busy && (r_pc == P_SCAN)))
        else $error("sequencer did not start at the scan step");

    // The group index never passes the end of the address.
    a_k_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && (r_pc != P_SCAN)) |-> (r_k <= 4'd8))
        else $error("group index beyond the last group");

    // The chosen zero run lies inside the eight groups.
    a_run_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && (r_pc != P_SCAN)) |-> ((5'(r_run.start) + 5'(r_run.len)) <= 5'd8))
        else $error("zero run extends past the last group");

endmodule

>>> test/tb_top.sv
// Self-checking testbench for the IPv6 address text formatter.
`timescale 1ns / 1ps

module tb_top;
    import ipv6f_pkg::*;

    // Run length limits.
    localparam int LIMIT_CYCLES = 400000;
    localparam int TAIL_CYCLES  = 100;
    localparam int RANDOM_ADDRS = 200;
    localparam int QUIET_TAIL   = 30;
    localparam int TEXT_MAX     = 39;

    // One expected character of the text.
    typedef struct packed {
        logic [6:0] ch;
        logic       is_last;
    } t_text_char;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ipv6f_addr_if addr_ch ();
    ipv6f_char_if char_ch ();

    ipv6_address_text_formatter i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_addr  (addr_ch),
        .o_char  (char_ch)
    );

    always #5 i_clk = ~i_clk;

    logic [127:0] addr_pending [$];
    t_text_char   text_due [$];
    t_text_char   due_char;
    logic [127:0] next_addr;
    logic [6:0]   text_buf [0:TEXT_MAX-1];
    int           text_len;
    logic         addr_took;
    int           send_gap;
    int           stall_left;
    int           addrs_total;
    int           addrs_accepted;
    int           dotted_count;
    int           chars_checked;
    int           mismatch_count;

    // Appends one character to the text under construction.
    function automatic void put_ch(input logic [6:0] c);
        if (text_len < TEXT_MAX) begin
            text_buf[text_len] = c;
            text_len++;
        end
    endfunction

    // Appends a byte in decimal without leading zeros.
    function automatic void put_dec_byte(input logic [7:0] b);
        if (b >= 8'd100) put_ch(CH_ZERO + 7'(b / 100));
        if (b >= 8'd10) put_ch(CH_ZERO + 7'((b / 10) % 10));
        put_ch(CH_ZERO + 7'(b % 10));
    endfunction

    // Works out the text of one address and queues its characters.
    function automatic void predict_text(input logic [63:0] hi, input logic [63:0] lo);
        logic [127:0] a;
        logic [15:0]  grp [0:7];
        logic [3:0]   d;
        logic         started;
        int           k, sh;
        int           best_start, best_len, run_start, run_len;
        a = {hi, lo};
        for (k = 0; k < 8; k++) grp[k] = a[127 - 16 * k -: 16];
        best_start = 0;
        best_len   = 0;
        run_start  = -1;
        run_len    = 0;
        text_len   = 0;

        // Longest run of zero groups, the earliest one on a tie.
        for (k = 0; k < 8; k++) begin
            if (grp[k] == 16'd0) begin
                if (run_start < 0) run_start = k;
                run_len++;
                if (run_len > best_len) begin
                    best_len   = run_len;
                    best_start = run_start;
                end
            end else begin
                run_start = -1;
                run_len   = 0;
            end
        end

        if (best_start == 0 && best_len == 6) begin
            // Groups 0 to 5 zero: dotted-quad tail.
            dotted_count++;
            put_ch(CH_COLON);
            put_ch(CH_COLON);
            put_dec_byte(lo[31:24]);
            put_ch(CH_DOT);
            put_dec_byte(lo[23:16]);
            put_ch(CH_DOT);
            put_dec_byte(lo[15:8]);
            put_ch(CH_DOT);
            put_dec_byte(lo[7:0]);
        end else begin
            k = 0;
            while (k < 8) begin
                if (k != 0) put_ch(CH_COLON);
                if (k == best_start && best_len != 0) begin
                    if (k == 0) put_ch(CH_COLON);
                    k += best_len;
                    if (k >= 8) put_ch(CH_COLON);
                end else begin
                    // Hex group without leading zeros.
                    started = 1'b0;
                    for (sh = 12; sh >= 0; sh -= 4) begin
                        d = grp[k][sh +: 4];
                        if (d != 4'd0 || started || sh == 0) begin
                            started = 1'b1;
                            put_ch(d < 4'd10 ? CH_ZERO + 7'(d) : CH_A + 7'(d) - 7'd10);
                        end
                    end
                    k++;
                end
            end
        end

        for (k = 0; k < text_len; k++) begin
            text_due.push_back('{ch: text_buf[k], is_last: (k == text_len - 1)});
        end
    endfunction

    // A group biased toward zero, short values and full-width values.
    function automatic logic [15:0] random_group();
        logic [15:0] g;
        case ($urandom_range(0, 5))
            0, 1: g = 16'd0;
            2: g = 16'($urandom_range(1, 15));
            3: g = 16'($urandom_range(1, 255)) << (4 * $urandom_range(0, 2));
            default: g = 16'($urandom);
        endcase
        return g;
    endfunction

    // A random address: mostly zero-run patterns, some dotted tails, some raw noise.
    function automatic logic [127:0] random_address();
        logic [127:0] a;
        int           k;
        a = '0;
        case ($urandom_range(0, 9))
            0, 1: begin
                a[31:16] = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(1, 65535))
                                                        : 16'($urandom_range(1, 255));
                a[15:0]  = random_group();
            end
            2: a = {$urandom, $urandom, $urandom, $urandom};
            default: begin
                for (k = 0; k < 8; k++) a[127 - 16 * k -: 16] = random_group();
            end
        endcase
        return a;
    endfunction

    // Acceptance of addresses and checking of characters.
    always @(posedge i_clk) begin
        addr_took <= i_rst_n && addr_ch.valid && addr_ch.ready;
        if (i_rst_n && addr_ch.valid && addr_ch.ready) begin
            predict_text(addr_ch.addr_high, addr_ch.addr_low);
            addrs_accepted++;
        end
        if (i_rst_n && char_ch.valid && char_ch.ready) begin
            if (text_due.size() == 0) begin
                $error("out_char %h arrived with no character expected", char_ch.out_char);
                mismatch_count++;
            end else begin
                due_char = text_due.pop_front();
                chars_checked++;
                if (char_ch.out_char !== due_char.ch) begin
                    $error("out_char mismatch: expected %h, got %h",
                           due_char.ch, char_ch.out_char);
                    mismatch_count++;
                end
                if (char_ch.last_char !== due_char.is_last) begin
                    $error("last_char mismatch: expected %b, got %b",
                           due_char.is_last, char_ch.last_char);
                    mismatch_count++;
                end
            end
        end
    end

    // Address driver with random gaps, none near the end of the run.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            addr_ch.valid <= 1'b0;
        end else if (!addr_ch.valid || addr_took) begin
            if (send_gap > 0) begin
                send_gap--;
                addr_ch.valid <= 1'b0;
            end else if (addr_pending.size() == 0) begin
                addr_ch.valid <= 1'b0;
            end else if (addr_pending.size() > QUIET_TAIL && $urandom_range(0, 3) == 0) begin
                send_gap = $urandom_range(0, 8);
                addr_ch.valid <= 1'b0;
            end else begin
                next_addr = addr_pending.pop_front();
                addr_ch.addr_high <= next_addr[127:64];
                addr_ch.addr_low  <= next_addr[63:0];
                addr_ch.valid     <= 1'b1;
            end
        end
    end

    // Character consumer with random stalls, none near the end of the run.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            char_ch.ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            char_ch.ready <= 1'b0;
        end else if (addr_pending.size() > QUIET_TAIL && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 8);
            char_ch.ready <= 1'b0;
        end else begin
            char_ch.ready <= 1'b1;
        end
    end

    // Watchdog.
    initial begin
        repeat (LIMIT_CYCLES) @(posedge i_clk);
        $display("Verification failed");
        $finish;
    end

    // Stimulus, reset and end of run.
    initial begin
        i_rst_n           = 1'b0;
        addr_ch.valid     = 1'b0;
        addr_ch.addr_high = '0;
        addr_ch.addr_low  = '0;
        char_ch.ready     = 1'b0;
        addr_took         = 1'b0;
        send_gap          = 0;
        stall_left        = 0;
        addrs_accepted    = 0;
        dotted_count      = 0;
        chars_checked     = 0;
        mismatch_count    = 0;
        text_len          = 0;

        // All-zero and all-ones addresses; the latter gives the longest text.
        addr_pending.push_back(128'h0000_0000_0000_0000_0000_0000_0000_0000);
        addr_pending.push_back(128'hffff_ffff_ffff_ffff_ffff_ffff_ffff_ffff);
        // Every hex digit, no zero group.
        addr_pending.push_back(128'h1234_5678_9abc_def0_0fed_cba9_8765_4321);
        // Zero run at the start, and at the end.
        addr_pending.push_back(128'h0000_0000_0000_0000_0000_0000_0000_0001);
        addr_pending.push_back(128'h0001_0000_0000_0000_0000_0000_0000_0000);
        addr_pending.push_back(128'h0001_0002_0003_0004_0005_0006_0000_0000);
        // Dotted-quad tail, with the last group zero and with byte extremes.
        addr_pending.push_back(128'h0000_0000_0000_0000_0000_0000_c0a8_0001);
        addr_pending.push_back(128'h0000_0000_0000_0000_0000_0000_0a00_0000);
        addr_pending.push_back(128'h0000_0000_0000_0000_0000_0000_ff63_0964);
        addr_pending.push_back(128'h0000_0000_0000_0000_0000_0000_0001_ffff);
        // A lone zero group is still compressed.
        addr_pending.push_back(128'h0001_0000_0002_0003_0004_0005_0006_0007);
        // Tied runs: the first one wins and the second is written out as zeros.
        addr_pending.push_back(128'h0001_0000_0000_0002_0000_0000_0003_0004);
        // A later, longer run beats an earlier single zero.
        addr_pending.push_back(128'h0000_0001_0000_0000_0000_0002_0003_0004);
        addr_pending.push_back(128'h2001_0db8_0000_0000_0000_ff00_0042_8329);
        // Five leading zero groups only: hex form, not dotted.
        addr_pending.push_back(128'h0000_0000_0000_0000_0000_ffff_c000_0280);
        addr_pending.push_back(128'h0000_0001_0000_0001_0000_0001_0000_0001);
        addr_pending.push_back(128'h8000_0000_0000_0000_0000_0000_0000_0001);
        // Leading-zero suppression inside groups.
        addr_pending.push_back(128'h0001_0010_0100_1000_00ab_0c0d_e000_000f);

        for (int k = 0; k < RANDOM_ADDRS; k++) addr_pending.push_back(random_address());
        addrs_total = addr_pending.size();

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        do @(negedge i_clk); while (addrs_accepted < addrs_total || text_due.size() != 0);
        repeat (TAIL_CYCLES) @(negedge i_clk);

        $display("Formatted %0d addresses, %0d of them in dotted-quad form.",
                 addrs_accepted, dotted_count);
        $display("Checked %0d text characters under random gaps and stalls.", chars_checked);
        if (mismatch_count == 0 && text_due.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
